### hdl/vmfa_pkg.sv
package vmfa_pkg;

  localparam longint TWOPI_Q32 = 64'sd26986075409;
  localparam longint HALFPI_Q32 = 64'sd6746518852;
  localparam logic signed [33:0] HALFPI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam int CORDIC_STEPS = 24;
  localparam int ENTRY_W = 24;
  localparam logic signed [55:0] ENTRY_MAX = 56'sd8388607;
  localparam logic signed [55:0] ENTRY_MIN = -56'sd8388608;

  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd2;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t [3:0] row_t;
  typedef row_t [2:0] mat_t;
  typedef logic signed [16:0] trig_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction

  function automatic trig_t to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    trig_t r;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) r = 17'sd32767;
    else if (t < -34'sd32768) r = -17'sd32768;
    else r = t[16:0];
    return r;
  endfunction

  function automatic entry_t rnd_sat(input logic signed [55:0] v, input int sh);
    logic signed [55:0] t;
    entry_t r;
    t = (v + (56'sd1 <<< (sh - 1))) >>> sh;
    if (t > ENTRY_MAX) r = ENTRY_MAX[ENTRY_W-1:0];
    else if (t < ENTRY_MIN) r = ENTRY_MIN[ENTRY_W-1:0];
    else r = t[ENTRY_W-1:0];
    return r;
  endfunction

endpackage

### hdl/vmfa_angle.sv
module vmfa_angle #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [17:0]   azimuth,
  input  logic signed [16:0]   elevation,
  output logic                 out_valid,
  output logic [AW-1:0]        az,
  output logic [AW-1:0]        el
);
  localparam longint TWOPI_F = (vmfa_pkg::TWOPI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS)))
                               >>> (32 - ANGLE_FRAC_BITS);
  localparam longint HALFPI_F = (vmfa_pkg::HALFPI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS)))
                                >>> (32 - ANGLE_FRAC_BITS);
  localparam int KP = 131071 / int'(TWOPI_F);
  localparam int KN = 131071 / int'(TWOPI_F) + 1;
  localparam logic signed [20:0] T21 = 21'(TWOPI_F);
  localparam logic [17:0] HP18 = 18'(HALFPI_F);

  logic [6:0] cp, cn;
  logic signed [20:0] az_s, az_w;
  logic [AW-1:0] az_next, el_next;

  always_comb begin
    cp = '0;
    cn = '0;
    for (int m = 1; m <= KP; m++) begin
      if (azimuth >= 18'(m * int'(TWOPI_F))) cp = cp + 7'd1;
    end
    for (int m = 1; m <= KN; m++) begin
      if (azimuth < -18'sd0 - 18'((m - 1) * int'(TWOPI_F))) cn = cn + 7'd1;
    end
    az_s = 21'(azimuth);
    az_w = az_s + $signed({14'd0, cn}) * T21 - $signed({14'd0, cp}) * T21;
    az_next = az_w[AW-1:0];
    if (elevation[16]) el_next = '0;
    else if ({1'b0, elevation} > HP18) el_next = AW'(HALFPI_F);
    else el_next = AW'(elevation[15:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
    az <= az_next;
    el <= el_next;
  end
endmodule

### hdl/vmfa_cordic.sv
module vmfa_cordic #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int AW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [AW-1:0]         angle,
  output logic                  out_valid,
  output vmfa_pkg::trig_t       sn,
  output vmfa_pkg::trig_t       cs,
  output logic [AW-1:0]         out_angle
);
  localparam int N = vmfa_pkg::CORDIC_STEPS;

  logic signed [33:0] xs [N+1];
  logic signed [33:0] ys [N+1];
  logic signed [33:0] zs [N+1];
  logic [1:0]         qs [N+1];
  logic [AW-1:0]      as [N+1];
  logic [N:0]         vs;

  logic signed [33:0] z_in, z_res;
  logic [1:0] q_in;
  vmfa_pkg::trig_t s_q, c_q;

  always_comb begin
    z_in = 34'(angle) <<< (30 - ANGLE_FRAC_BITS);
    if (z_in >= 3 * vmfa_pkg::HALFPI_Q30) q_in = 2'd3;
    else if (z_in >= 2 * vmfa_pkg::HALFPI_Q30) q_in = 2'd2;
    else if (z_in >= vmfa_pkg::HALFPI_Q30) q_in = 2'd1;
    else q_in = 2'd0;
    z_res = z_in - $signed({32'd0, q_in}) * vmfa_pkg::HALFPI_Q30;
  end

  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else vs[0] <= in_valid;
    xs[0] <= vmfa_pkg::CORDIC_GAIN_Q30;
    ys[0] <= '0;
    zs[0] <= z_res;
    qs[0] <= q_in;
    as[0] <= angle;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
      if (!zs[i][33]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - vmfa_pkg::atan_q30(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + vmfa_pkg::atan_q30(i);
      end
      qs[i+1] <= qs[i];
      as[i+1] <= as[i];
    end
  end

  assign s_q = vmfa_pkg::to_q15(ys[N]);
  assign c_q = vmfa_pkg::to_q15(xs[N]);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vs[N];
    out_angle <= as[N];
    case (qs[N])
      2'd0: begin
        sn <= s_q;
        cs <= c_q;
      end
      2'd1: begin
        sn <= c_q;
        cs <= -s_q;
      end
      2'd2: begin
        sn <= -s_q;
        cs <= -c_q;
      end
      default: begin
        sn <= -c_q;
        cs <= s_q;
      end
    endcase
  end
endmodule

### hdl/vmfa_matrix.sv
module vmfa_matrix #(
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  vmfa_pkg::trig_t      sa,
  input  vmfa_pkg::trig_t      ca,
  input  vmfa_pkg::trig_t      se,
  input  vmfa_pkg::trig_t      ce,
  input  logic [AW-1:0]        az_in,
  input  logic [AW-1:0]        el_in,
  input  logic [15:0]          scale,
  input  logic signed [15:0]   origin_x,
  input  logic signed [15:0]   origin_y,
  output logic                 out_valid,
  output vmfa_pkg::mat_t       mat,
  output logic [AW-1:0]        az_out,
  output logic [AW-1:0]        el_out
);
  logic signed [16:0] sc;
  assign sc = $signed({1'b0, scale});

  // stage 1: first products
  logic v1;
  logic [AW-1:0] az1, el1;
  logic signed [33:0] ssa, sca, sse, sce, pa, pb, pc, pd;
  logic signed [34:0] ssum, pe, pf;
  logic signed [17:0] sum_in, dif_in;

  assign sum_in = 18'(sa) + 18'(ca);
  assign dif_in = 18'(sa) - 18'(ca);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    az1 <= az_in;
    el1 <= el_in;
    ssa <= sc * sa;
    sca <= sc * ca;
    sse <= sc * se;
    sce <= sc * ce;
    ssum <= sc * sum_in;
    pa <= se * ca;
    pb <= se * sa;
    pc <= ce * ca;
    pd <= ce * sa;
    pe <= se * dif_in;
    pf <= ce * dif_in;
  end

  // stage 2: scaled triple products
  logic v2;
  logic [AW-1:0] az2, el2;
  logic signed [33:0] ssa2, sca2, sse2, sce2;
  logic signed [34:0] ssum2;
  logic signed [50:0] q10, q11, q20, q21;
  logic signed [51:0] q13, q23;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    az2 <= az1;
    el2 <= el1;
    ssa2 <= ssa;
    sca2 <= sca;
    sse2 <= sse;
    sce2 <= sce;
    ssum2 <= ssum;
    q10 <= sc * pa;
    q11 <= sc * pb;
    q20 <= sc * pc;
    q21 <= sc * pd;
    q13 <= sc * pe;
    q23 <= sc * pf;
  end

  // stage 3: offsets, rounding, saturation
  vmfa_pkg::mat_t m_next;
  logic signed [55:0] ox56, oy56;

  always_comb begin
    ox56 = 56'(origin_x) <<< 20;
    oy56 = 56'(origin_y) <<< 35;
    m_next[0][0] = vmfa_pkg::rnd_sat(56'(ssa2), 15);
    m_next[0][1] = vmfa_pkg::rnd_sat(56'(sca2), 15);
    m_next[0][2] = '0;
    m_next[0][3] = vmfa_pkg::rnd_sat(ox56 - 56'(ssum2), 16);
    m_next[1][0] = vmfa_pkg::rnd_sat(-56'(q10), 30);
    m_next[1][1] = vmfa_pkg::rnd_sat(56'(q11), 30);
    m_next[1][2] = vmfa_pkg::rnd_sat(56'(sce2), 15);
    m_next[1][3] = vmfa_pkg::rnd_sat(oy56 - 56'(q13), 31);
    m_next[2][0] = vmfa_pkg::rnd_sat(56'(q20), 30);
    m_next[2][1] = vmfa_pkg::rnd_sat(-56'(q21), 30);
    m_next[2][2] = vmfa_pkg::rnd_sat(56'(sse2), 15);
    m_next[2][3] = vmfa_pkg::rnd_sat(-56'(q23), 31);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v2;
    az_out <= az2;
    el_out <= el2;
    mat <= m_next;
  end
endmodule

### hdl/view_matrix_from_angles_top.sv
// Turns an azimuth/elevation pair into a 3x4 view matrix, delivered as three row
// results on consecutive cycles, each marked by result_valid for one cycle; the
// receiver cannot stall. An item is taken when start is high and busy is low,
// after which busy stays high until the row output can take the next item's
// three rows; a new item can enter while earlier ones are still in the
// pipeline. Row 0 follows the angle wrap and clamp register, the two pipelined
// CORDIC units, the multiply, round and saturate stages, and the row output
// register. Configuration writes are always ready and should be made while
// no item is in flight.
module view_matrix_from_angles_top #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [17:0]   azimuth,
  input  logic signed [16:0]   elevation,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 result_valid,
  output logic [1:0]           row_index,
  output logic signed [23:0]   entry_0,
  output logic signed [23:0]   entry_1,
  output logic signed [23:0]   entry_2,
  output logic signed [23:0]   entry_3,
  output logic                 last_row,
  output logic [15:0]          azimuth_out,
  output logic [13:0]          elevation_out
);
  localparam longint TWOPI_F = (vmfa_pkg::TWOPI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS)))
                               >>> (32 - ANGLE_FRAC_BITS);
  localparam int AW = $clog2(TWOPI_F);

  logic [15:0] scale;
  logic signed [15:0] origin_x, origin_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= 16'd256;
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vmfa_pkg::REG_SCALE:    scale <= cfg_data;
        vmfa_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        vmfa_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  logic [1:0] hold;

  assign accept = start && !busy;
  assign busy = hold != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) hold <= 2'd0;
    else if (accept) hold <= 2'd2;
    else if (hold != 2'd0) hold <= hold - 2'd1;
  end

  logic a_valid;
  logic [AW-1:0] a_az, a_el;

  vmfa_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)) u_angle (
    .clk(clk), .rst(rst), .in_valid(accept), .azimuth(azimuth), .elevation(elevation),
    .out_valid(a_valid), .az(a_az), .el(a_el)
  );

  logic c_valid, c_valid_el;
  vmfa_pkg::trig_t sa, ca, se, ce;
  logic [AW-1:0] c_az, c_el;

  vmfa_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)) u_cordic_az (
    .clk(clk), .rst(rst), .in_valid(a_valid), .angle(a_az),
    .out_valid(c_valid), .sn(sa), .cs(ca), .out_angle(c_az)
  );

  vmfa_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)) u_cordic_el (
    .clk(clk), .rst(rst), .in_valid(a_valid), .angle(a_el),
    .out_valid(c_valid_el), .sn(se), .cs(ce), .out_angle(c_el)
  );

  logic m_valid;
  vmfa_pkg::mat_t mat;
  logic [AW-1:0] m_az, m_el;

  vmfa_matrix #(.AW(AW)) u_matrix (
    .clk(clk), .rst(rst), .in_valid(c_valid && c_valid_el),
    .sa(sa), .ca(ca), .se(se), .ce(ce), .az_in(c_az), .el_in(c_el),
    .scale(scale), .origin_x(origin_x), .origin_y(origin_y),
    .out_valid(m_valid), .mat(mat), .az_out(m_az), .el_out(m_el)
  );

  // row output: bank loads, then one row per cycle
  vmfa_pkg::mat_t bank;
  logic [AW-1:0] bank_az, bank_el;
  logic [1:0] row;

  always_ff @(posedge clk) begin
    if (rst) row <= 2'd0;
    else if (m_valid) row <= 2'd1;
    else if (row == 2'd3) row <= 2'd0;
    else if (row != 2'd0) row <= row + 2'd1;
    if (m_valid) begin
      bank <= mat;
      bank_az <= m_az;
      bank_el <= m_el;
    end
  end

  logic [1:0] ridx;
  assign ridx = row - 2'd1;

  always_comb begin
    result_valid = row != 2'd0;
    row_index = ridx;
    last_row = row == 2'd3;
    azimuth_out = 16'(bank_az);
    elevation_out = 14'(bank_el);
    case (ridx)
      2'd0, 2'd1, 2'd2: begin
        entry_0 = bank[ridx][0];
        entry_1 = bank[ridx][1];
        entry_2 = bank[ridx][2];
        entry_3 = bank[ridx][3];
      end
      default: begin
        entry_0 = '0;
        entry_1 = '0;
        entry_2 = '0;
        entry_3 = '0;
      end
    endcase
  end
endmodule

### hdl/vmfa_checker.sv
module vmfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [1:0]  row_index,
  input logic        last_row,
  input logic [15:0] azimuth_out,
  input logic [13:0] elevation_out
);
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after input transfer");

  a_rows_in_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && row_index != 2'd2 |=> result_valid && row_index == $past(row_index) + 2'd1)
    else $error("matrix rows out of order");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> last_row == (row_index == 2'd2)) else $error("last_row mismatch");

  a_angles_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && row_index != 2'd2 |=> $stable(azimuth_out) && $stable(elevation_out))
    else $error("angles changed within a matrix");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> row_index == 2'd0 || row_index == 2'd1 || row_index == 2'd2)
    else $error("row index out of range");
endmodule

bind view_matrix_from_angles_top vmfa_checker u_vmfa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .row_index(row_index), .last_row(last_row), .azimuth_out(azimuth_out),
  .elevation_out(elevation_out)
);

### bench/view_matrix_from_angles_top_test.sv
`timescale 1ns / 100ps

module view_matrix_from_angles_top_test;

  localparam int FRAC = 13;
  localparam longint TWOPI = 51472;
  localparam longint HALFPI = 12868;
  localparam longint HALFPI30 = 1686629713;
  localparam longint GAIN30 = 652032874;
  localparam int LATENCY = 40;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [17:0] az;
    logic signed [16:0] el;
  } angles_t;

  typedef struct packed {
    logic [1:0] row;
    logic [23:0] e0;
    logic [23:0] e1;
    logic [23:0] e2;
    logic [23:0] e3;
    logic last;
    logic [15:0] az;
    logic [13:0] el;
  } row_result_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [17:0] azimuth = 0;
  logic signed [16:0] elevation = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = vmfa_pkg::REG_SCALE;
  logic [15:0] cfg_data = 0;
  logic result_valid;
  logic [1:0] row_index;
  logic signed [23:0] entry_0, entry_1, entry_2, entry_3;
  logic last_row;
  logic [15:0] azimuth_out;
  logic [13:0] elevation_out;

  view_matrix_from_angles_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  angles_t pending[$];
  row_result_t expected_rows[$];
  int errors = 0;
  int cycles = 0;
  longint scale_reg = 256, ox_reg = 0, oy_reg = 0;
  bit pause_req = 0;
  int gap = 0, burst = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_q15(longint v);
    v = rshift(v, 15);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clip_entry(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return t[i];
    return 64'sd1 <<< (30 - i);
  endfunction

  task automatic rotate(input longint ang, output longint sn, output longint cs);
    longint z, x, y, nx, s, c;
    int q;
    z = ang * (64'sd1 <<< (30 - FRAC));
    x = GAIN30;
    y = 0;
    q = 0;
    while (q < 3 && z >= HALFPI30) begin
      z -= HALFPI30;
      q++;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= atan_step(i);
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); z += atan_step(i);
      end
      x = nx;
    end
    s = clip_q15(y);
    c = clip_q15(x);
    case (q)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  task automatic predict_matrix(input angles_t a);
    longint az, el, sa, ca, se, ce, sc;
    longint m[3][4];
    row_result_t r;
    az = a.az;
    el = a.el;
    sc = scale_reg;
    az = ((az % TWOPI) + TWOPI) % TWOPI;
    if (el > HALFPI) el = HALFPI;
    if (el < 0) el = 0;
    rotate(az, sa, ca);
    rotate(el, se, ce);
    m[0][0] = rshift(sc * sa, 15);
    m[0][1] = rshift(sc * ca, 15);
    m[0][2] = 0;
    m[0][3] = rshift(ox_reg * (64'sd1 <<< 20) - sc * (sa + ca), 16);
    m[1][0] = rshift(-(sc * se * ca), 30);
    m[1][1] = rshift(sc * se * sa, 30);
    m[1][2] = rshift(sc * ce, 15);
    m[1][3] = rshift(oy_reg * (64'sd1 <<< 35) - sc * se * (sa - ca), 31);
    m[2][0] = rshift(sc * ce * ca, 30);
    m[2][1] = rshift(-(sc * ce * sa), 30);
    m[2][2] = rshift(sc * se, 15);
    m[2][3] = rshift(-(sc * ce * (sa - ca)), 31);
    for (int i = 0; i < 3; i++) begin
      r.row = i[1:0];
      r.e0 = 24'(clip_entry(m[i][0]));
      r.e1 = 24'(clip_entry(m[i][1]));
      r.e2 = 24'(clip_entry(m[i][2]));
      r.e3 = 24'(clip_entry(m[i][3]));
      r.last = (i == 2);
      r.az = az[15:0];
      r.el = el[13:0];
      expected_rows.push_back(r);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_matrix('{az: azimuth, el: elevation});
        void'(pending.pop_front());
      end
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (pause_req || pending.size() == 0) begin
        start <= 0;
      end else begin
        if (start && !busy && burst > 0) begin
          azimuth <= pending[0].az;
          elevation <= pending[0].el;
          start <= 1;
          burst <= burst - 1;
        end else if (start && !busy) begin
          start <= 0;
          if (pending.size() > 1) begin
            gap <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            burst <= $urandom_range(0, 12);
          end
        end else if (!start) begin
          azimuth <= pending[0].az;
          elevation <= pending[0].el;
          start <= 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    row_result_t w;
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && result_valid) begin
      if (expected_rows.size() == 0) begin
        report("unexpected row", row_index, 0);
      end else begin
        w = expected_rows.pop_front();
        if (row_index !== w.row) report("row_index", row_index, w.row);
        if (entry_0 !== w.e0) report("entry_0", entry_0, w.e0);
        if (entry_1 !== w.e1) report("entry_1", entry_1, w.e1);
        if (entry_2 !== w.e2) report("entry_2", entry_2, w.e2);
        if (entry_3 !== w.e3) report("entry_3", entry_3, w.e3);
        if (last_row !== w.last) report("last_row", last_row, w.last);
        if (azimuth_out !== w.az) report("azimuth_out", azimuth_out, w.az);
        if (elevation_out !== w.el) report("elevation_out", elevation_out, w.el);
      end
    end
  end

  task automatic drain;
    while (pending.size() != 0 || start || expected_rows.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      vmfa_pkg::REG_SCALE: scale_reg = val;
      vmfa_pkg::REG_ORIGIN_X: ox_reg = $signed(val);
      vmfa_pkg::REG_ORIGIN_Y: oy_reg = $signed(val);
      default: ;
    endcase
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic angles_t rand_angles();
    angles_t a;
    case ($urandom_range(0, 9))
      0: a.az = 18'($urandom());
      1: a.az = 18'($urandom_range(0, 40) + (TWOPI - 20));
      2: a.az = $signed(18'($urandom_range(0, 51471))) - 18'sd51471;
      default: a.az = 18'($urandom_range(0, 102943));
    endcase
    case ($urandom_range(0, 9))
      0: a.el = 17'($urandom());
      1: a.el = 17'($urandom_range(0, 40) + (HALFPI - 20));
      2: a.el = -$signed(17'($urandom_range(0, 51471)));
      default: a.el = 17'($urandom_range(0, 12868));
    endcase
    return a;
  endfunction

  initial begin
    longint dir_az[12] = '{0, 1, -1, -51471, 102943, 51471, 51472, 12868, 25736,
                           38604, -131072, 131071};
    longint dir_el[12] = '{0, 1, -1, -51471, 51471, 12868, 12869, 12867, 6434,
                           -65536, 65535, 100};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 12; i++) pending.push_back('{az: 18'(dir_az[i]), el: 17'(dir_el[i])});
    drain();
    write_reg(vmfa_pkg::REG_SCALE, 16'hFFFF);
    write_reg(vmfa_pkg::REG_ORIGIN_X, 16'h7FFF);
    write_reg(vmfa_pkg::REG_ORIGIN_Y, 16'h8000);
    for (int i = 0; i < 12; i++) pending.push_back('{az: 18'(dir_az[i]), el: 17'(dir_el[i])});
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(vmfa_pkg::REG_SCALE, 16'h0000);
          write_reg(vmfa_pkg::REG_ORIGIN_X, 16'h8000);
          write_reg(vmfa_pkg::REG_ORIGIN_Y, 16'h7FFF);
        end
        default: begin
          write_reg(vmfa_pkg::REG_SCALE, 16'($urandom()));
          write_reg(vmfa_pkg::REG_ORIGIN_X, 16'($urandom()));
          write_reg(vmfa_pkg::REG_ORIGIN_Y, 16'($urandom()));
        end
      endcase
      for (int i = 0; i < 50; i++) pending.push_back(rand_angles());
      while (pending.size() > 25) @(posedge clk);
      pause_req = 1;
      while (start || expected_rows.size() != 0) @(posedge clk);
      pause_req = 0;
      drain();
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
